@@ rtl/fuel_refill_detector_top_macros.svh @@
// ---------------------------------------------------------------------------
// fuel_refill_detector_top_macros.svh
// Assertion shorthands for the refill detector checker.
// ---------------------------------------------------------------------------
`ifndef FUEL_REFILL_DETECTOR_TOP_MACROS_SVH
`define FUEL_REFILL_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, masked during reset
`define FRD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset
`define FRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen
`define FRD_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fuel_rd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fuel_rd_pkg
// Types, codes and constants shared by the refill detector modules.
// ---------------------------------------------------------------------------
package fuel_rd_pkg;

   // Request opcodes
   localparam logic [2:0] OP_RESTORE = 3'd0;
   localparam logic [2:0] OP_STOP    = 3'd1;
   localparam logic [2:0] OP_KEY_ON  = 3'd2;
   localparam logic [2:0] OP_TICK    = 3'd3;
   localparam logic [2:0] OP_EDGE    = 3'd4;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRESH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DENSITY   = 2'd3;

   // Register reset values
   localparam logic [7:0]  THRESHOLD_RST = 8'd10;
   localparam logic [7:0]  FRESH_RST     = 8'd128;
   localparam logic [15:0] VOLUME_RST    = 16'd100;
   localparam logic [7:0]  DENSITY_RST   = 8'd0;

   // Arithmetic constants
   localparam logic [7:0]  FACTOR_MAX       = 8'd128;
   localparam logic [15:0] SHORT_TIME_LIMIT = 16'd8191;
   localparam int          SHORT_SHIFT      = 19;
   localparam int          LONG_SHIFT       = 16;
   localparam int          POST_SHIFT       = 3;
   localparam logic [10:0] DENSITY_BASE     = 11'd1792;
   localparam logic [15:0] SAT16            = 16'hFFFF;

   // Divider geometry
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 28;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  fuel_level;
      logic [15:0] injection_time;
      logic [15:0] injector_flow;
      logic        reset_done;
      logic [7:0]  previous_factor;
      logic [7:0]  stored_factor;
      logic        stored_request;
   } req_type;

   typedef struct packed {
      logic        refill_detected;
      logic [7:0]  reset_factor;
      logic        reset_request;
      logic [7:0]  level_rise;
      logic [15:0] fuel_per_tdc;
      logic [15:0] consumed_since_refill;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  refill_threshold;
      logic [7:0]  fresh_fuel_factor;
      logic [15:0] circuit_volume;
      logic [7:0]  fuel_density;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic ready;
      logic finish;
   } core_sts_type;

endpackage

@@ rtl/fuel_rd_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fuel_rd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fuel_rd_div (
   input  logic                     clock,
   input  logic                     reset,
   input  fuel_rd_pkg::div_req_type div_req,
   output fuel_rd_pkg::div_rsp_type div_rsp
);
   import fuel_rd_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // Shift in next dividend bit and try the subtraction
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W - 1);
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ rtl/fuel_rd_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fuel_rd_core
// Sequencer, detector state and shared multiplier; drives the divider.
// ---------------------------------------------------------------------------
module fuel_rd_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  fuel_rd_pkg::req_type      req_data,
   input  fuel_rd_pkg::cfg_type      cfg,
   input  logic                      load_ok,
   output fuel_rd_pkg::core_sts_type sts,
   output fuel_rd_pkg::rsp_type      state_out
);
   import fuel_rd_pkg::*;

   // Sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_EXEC     = 4'd1;
   localparam logic [3:0] ST_MUL_A    = 4'd2;
   localparam logic [3:0] ST_MUL_B    = 4'd3;
   localparam logic [3:0] ST_BLEND    = 4'd4;
   localparam logic [3:0] ST_DIV_GO   = 4'd5;
   localparam logic [3:0] ST_DIV_WAIT = 4'd6;
   localparam logic [3:0] ST_TICK_ACC = 4'd7;
   localparam logic [3:0] ST_TICK_CMP = 4'd8;
   localparam logic [3:0] ST_DONE     = 4'd9;

   // Divider passes
   localparam logic [1:0] PASS_SHORT = 2'd0;
   localparam logic [1:0] PASS_LONG1 = 2'd1;
   localparam logic [1:0] PASS_LONG2 = 2'd2;
   localparam logic [1:0] PASS_BLEND = 2'd3;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  pass_ff, pass_in;
   req_type     req_ff, req_in;
   logic signed [29:0] acc_ff, acc_in;
   logic [21:0] quot_ff, quot_in;

   // Detector state
   logic [7:0]  old_level_ff, old_level_in;
   logic [7:0]  new_level_ff, new_level_in;
   logic        refill_ff, refill_in;
   logic        refill_prev_ff, refill_prev_in;
   logic        done_prev_ff, done_prev_in;
   logic [7:0]  rise_ff, rise_in;
   logic [7:0]  factor_ff, factor_in;
   logic        request_ff, request_in;
   logic [15:0] tdc_ff, tdc_in;
   logic [15:0] cons_ff, cons_in;

   logic signed [17:0] mul_a;
   logic signed [11:0] mul_b;
   logic signed [29:0] product;
   logic [16:0] k_plus1;
   logic [10:0] dens;
   logic [8:0]  factor_diff;
   logic [7:0]  rise_calc;
   logic [16:0] cons_sum;
   logic [19:0] cons_limit;
   logic        done_edge;
   logic [DIVIDEND_W-1:0] quotient;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign k_plus1     = {1'b0, req_ff.injector_flow} + 17'd1;
   assign dens        = {3'b000, cfg.fuel_density} + DENSITY_BASE;
   assign factor_diff = {1'b0, req_ff.previous_factor} - {1'b0, cfg.fresh_fuel_factor};
   assign rise_calc   = (req_ff.fuel_level > old_level_ff) ?
                        (req_ff.fuel_level - old_level_ff) : 8'd0;
   assign cons_sum    = {1'b0, cons_ff} + {1'b0, tdc_ff};
   // 10 x volume as shift-and-add
   assign cons_limit  = {1'b0, cfg.circuit_volume, 3'b000} + {3'b000, cfg.circuit_volume, 1'b0};
   assign done_edge   = req_ff.reset_done & ~done_prev_ff;
   assign quotient    = div_rsp.quotient;

   // Shared multiplier, operands chosen by the step in progress
   always_comb begin
      mul_a = $signed({1'b0, k_plus1});
      mul_b = $signed({1'b0, dens});
      if (req_ff.opcode == OP_EDGE) begin
         if (state_ff == ST_MUL_B) begin
            mul_a = $signed({10'd0, new_level_ff});
            mul_b = $signed({4'd0, cfg.fresh_fuel_factor});
         end else begin
            mul_a = $signed({10'd0, old_level_ff});
            mul_b = $signed({{3{factor_diff[8]}}, factor_diff});
         end
      end
   end
   assign product = mul_a * mul_b;

   // Divider operands per pass
   always_comb begin
      div_req.start = (state_ff == ST_DIV_GO);
      unique case (pass_ff)
         PASS_SHORT: begin
            div_req.dividend = {req_ff.injection_time[DIVIDEND_W-SHORT_SHIFT-1:0],
                                {SHORT_SHIFT{1'b0}}};
            div_req.divisor  = acc_ff[DIVISOR_W-1:0];
         end
         PASS_LONG1: begin
            div_req.dividend = {req_ff.injection_time, {LONG_SHIFT{1'b0}}};
            div_req.divisor  = {{(DIVISOR_W-11){1'b0}}, dens};
         end
         PASS_LONG2: begin
            div_req.dividend = {{(DIVIDEND_W-22-POST_SHIFT){1'b0}}, quot_ff,
                                {POST_SHIFT{1'b0}}};
            div_req.divisor  = {{(DIVISOR_W-17){1'b0}}, k_plus1};
         end
         PASS_BLEND: begin
            div_req.dividend = {{(DIVIDEND_W-17){1'b0}}, acc_ff[16:0]};
            div_req.divisor  = {{(DIVISOR_W-8){1'b0}}, new_level_ff};
         end
         default: begin
            div_req.dividend = '0;
            div_req.divisor  = '0;
         end
      endcase
   end

   fuel_rd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequencer and state updates
   always_comb begin
      state_in       = state_ff;
      pass_in        = pass_ff;
      req_in         = req_ff;
      acc_in         = acc_ff;
      quot_in        = quot_ff;
      old_level_in   = old_level_ff;
      new_level_in   = new_level_ff;
      refill_in      = refill_ff;
      refill_prev_in = refill_prev_ff;
      done_prev_in   = done_prev_ff;
      rise_in        = rise_ff;
      factor_in      = factor_ff;
      request_in     = request_ff;
      tdc_in         = tdc_ff;
      cons_in        = cons_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (req_ff.opcode)
               OP_RESTORE: begin
                  factor_in  = (req_ff.stored_factor > FACTOR_MAX) ?
                               FACTOR_MAX : req_ff.stored_factor;
                  request_in = req_ff.stored_request;
               end
               OP_STOP: begin
                  old_level_in = req_ff.fuel_level;
               end
               OP_KEY_ON: begin
                  new_level_in = req_ff.fuel_level;
                  if (!refill_ff) begin
                     rise_in        = rise_calc;
                     refill_prev_in = 1'b0;
                     refill_in      = rise_calc >= cfg.refill_threshold;
                  end
               end
               OP_TICK: begin
                  if (req_ff.injection_time < SHORT_TIME_LIMIT) begin
                     pass_in  = PASS_SHORT;
                     state_in = ST_MUL_A;
                  end else begin
                     pass_in  = PASS_LONG1;
                     state_in = ST_DIV_GO;
                  end
               end
               OP_EDGE: begin
                  if (refill_ff && !refill_prev_ff) begin
                     pass_in  = PASS_BLEND;
                     state_in = ST_MUL_A;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_MUL_A: begin
            acc_in   = product;
            state_in = (req_ff.opcode == OP_EDGE) ? ST_MUL_B : ST_DIV_GO;
         end
         ST_MUL_B: begin
            acc_in   = acc_ff + product;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            // negative blend clamps to 0, empty tank gives the maximum
            priority if (acc_ff < 0) begin
               factor_in = 8'd0;
               cons_in   = '0;
               state_in  = ST_DONE;
            end else if (new_level_ff == 8'd0) begin
               factor_in = FACTOR_MAX;
               cons_in   = '0;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               unique case (pass_ff)
                  PASS_LONG1: begin
                     quot_in  = quotient[21:0];
                     pass_in  = PASS_LONG2;
                     state_in = ST_DIV_GO;
                  end
                  PASS_BLEND: begin
                     factor_in = ((|quotient[DIVIDEND_W-1:8]) || (quotient[7:0] > FACTOR_MAX)) ?
                                 FACTOR_MAX : quotient[7:0];
                     cons_in   = '0;
                     state_in  = ST_DONE;
                  end
                  default: begin
                     tdc_in   = (|quotient[DIVIDEND_W-1:16]) ? SAT16 : quotient[15:0];
                     state_in = ST_TICK_ACC;
                  end
               endcase
            end
         end
         ST_TICK_ACC: begin
            if (refill_ff) begin
               cons_in = cons_sum[16] ? SAT16 : cons_sum[15:0];
            end
            state_in = ST_TICK_CMP;
         end
         ST_TICK_CMP: begin
            if (refill_ff) begin
               request_in = {4'd0, cons_ff} >= cons_limit;
            end
            if (done_edge) begin
               refill_in  = 1'b0;
               request_in = 1'b0;
            end
            refill_prev_in = refill_ff & ~done_edge;
            done_prev_in   = req_ff.reset_done;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (load_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pass_ff        <= PASS_SHORT;
         old_level_ff   <= '0;
         new_level_ff   <= '0;
         refill_ff      <= 1'b0;
         refill_prev_ff <= 1'b0;
         done_prev_ff   <= 1'b0;
         rise_ff        <= '0;
         factor_ff      <= FACTOR_MAX;
         request_ff     <= 1'b0;
         tdc_ff         <= '0;
         cons_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         pass_ff        <= pass_in;
         old_level_ff   <= old_level_in;
         new_level_ff   <= new_level_in;
         refill_ff      <= refill_in;
         refill_prev_ff <= refill_prev_in;
         done_prev_ff   <= done_prev_in;
         rise_ff        <= rise_in;
         factor_ff      <= factor_in;
         request_ff     <= request_in;
         tdc_ff         <= tdc_in;
         cons_ff        <= cons_in;
      end
      req_ff  <= req_in;
      acc_ff  <= acc_in;
      quot_ff <= quot_in;
   end

   assign sts.ready  = (state_ff == ST_IDLE);
   assign sts.finish = (state_ff == ST_DONE);

   assign state_out.refill_detected       = refill_ff;
   assign state_out.reset_factor          = factor_ff;
   assign state_out.reset_request         = request_ff;
   assign state_out.level_rise            = rise_ff;
   assign state_out.fuel_per_tdc          = tdc_ff;
   assign state_out.consumed_since_refill = cons_ff;

endmodule

@@ rtl/fuel_refill_detector_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fuel_refill_detector_top
// Tank refill detector with fuel-quality reset factor and consumption watch.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : valid/ready request channel, one opcode per request.
//   rsp_*  : valid/ready result channel, exactly one result per request,
//            carrying the detector state after that request.
//   csr_*  : write-only register port, one write per cycle with csr_write.
// Work done between accept and rsp_valid:
//   restore, engine stop, key on, edge check without edge, unused: no arithmetic;
//   edge check whose blend clamps without dividing: two multiplies;
//   tick with short injection time: one multiply, one 32-step
//   division; tick with long injection time: two divisions;
//   edge check with blend: two multiplies, one division.
//   The single radix-2 divider serves every division.
// Only one request is in work at a time; req_ready rises with rsp_valid. A new
// request may be taken while the previous result waits in the output
// register. If rsp_ready stays low, the finished request waits in the core
// until the output register frees up.
// Reset clears all detector state (factor to 128), the registers to their
// defaults and drops rsp_valid.
// ---------------------------------------------------------------------------
module fuel_refill_detector_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  fuel_rd_pkg::req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output fuel_rd_pkg::rsp_type                   rsp_data,
   input  logic                                   csr_write,
   input  logic [fuel_rd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fuel_rd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fuel_rd_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         load;
   core_sts_type sts;
   rsp_type      core_state;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_THRESHOLD: cfg_in.refill_threshold  = csr_wdata[7:0];
            CSR_FRESH:     cfg_in.fresh_fuel_factor = csr_wdata[7:0];
            CSR_VOLUME:    cfg_in.circuit_volume    = csr_wdata;
            CSR_DENSITY:   cfg_in.fuel_density      = csr_wdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   fuel_rd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid & req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .load_ok   (load),
      .sts       (sts),
      .state_out (core_state)
   );

   // Output register
   assign load = sts.finish & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.refill_threshold  <= THRESHOLD_RST;
         cfg_ff.fresh_fuel_factor <= FRESH_RST;
         cfg_ff.circuit_volume    <= VOLUME_RST;
         cfg_ff.fuel_density      <= DENSITY_RST;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_ff <= core_state;
      end
   end

   assign req_ready = sts.ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/fuel_rd_chk.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fuel_rd_chk
// Port-level checks on the refill detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "fuel_refill_detector_top_macros.svh"

module fuel_rd_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input fuel_rd_pkg::rsp_type rsp_data
);
   import fuel_rd_pkg::*;

   // A stalled result stays offered and unchanged
   `FRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `FRD_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "stalled result changed")

   // Reset factor never leaves its range
   `FRD_ASSERT_NOW(a_factor_range, rsp_valid, rsp_data.reset_factor <= FACTOR_MAX, "factor above 128")

   // One request at a time: busy right after an accept
   `FRD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "second request taken")

   // No result straight out of reset
   `FRD_ASSERT_AFTER_RESET(a_reset_quiet, !rsp_valid, "result valid after reset")

endmodule

bind fuel_refill_detector_top fuel_rd_chk u_fuel_rd_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the fuel refill detector.
// ---------------------------------------------------------------------------
// Requests go in through a queue-fed driver with random gaps; results are
// taken by a monitor with random back-pressure. Every accepted request is run
// through a local model of the detector (refill detection, factor blend,
// fuel-per-TDC conversion and consumption watch), and the predicted state is
// compared field by field with the next result. A short directed run covers
// the corner cases, then random phases under several register settings mix
// well-formed stop / key-on / edge-check / tick sequences with noise.
// ---------------------------------------------------------------------------
module tb;
   import fuel_rd_pkg::*;

   localparam int unsigned CONSUME_MULT = 10;
   localparam int unsigned PHASE_REQUESTS = 205;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Register copies held by the model
   logic [7:0]  cfg_threshold = THRESHOLD_RST;
   logic [7:0]  cfg_fresh     = FRESH_RST;
   logic [15:0] cfg_volume    = VOLUME_RST;
   logic [7:0]  cfg_density   = DENSITY_RST;

   // Detector state held by the model
   logic [7:0]  stop_level   = '0;
   logic [7:0]  key_level    = '0;
   logic        refill_on    = 1'b0;
   logic        refill_last  = 1'b0;
   logic        done_last    = 1'b0;
   logic [7:0]  rise_last    = '0;
   logic [7:0]  quality_rst  = FACTOR_MAX;
   logic        adapt_req    = 1'b0;
   logic [15:0] fuel_tdc     = '0;
   logic [15:0] fuel_used    = '0;

   req_type request_q[$];
   rsp_type state_due_q[$];
   int unsigned requests_queued = 0;
   int unsigned results_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   int unsigned recv_draw = 0;
   bit send_quiet = 1'b0;
   bit recv_quiet = 1'b0;

   fuel_refill_detector_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Model: apply one request, return the detector state after it
   function automatic rsp_type refill_state_after(input req_type r);
      rsp_type s;
      logic [31:0] t32, k32, dens, quot, sum;
      int mix, q_int;
      case (r.opcode)
         OP_RESTORE: begin
            quality_rst = (r.stored_factor > FACTOR_MAX) ? FACTOR_MAX : r.stored_factor;
            adapt_req = r.stored_request;
         end
         OP_STOP: begin
            stop_level = r.fuel_level;
         end
         OP_KEY_ON: begin
            key_level = r.fuel_level;
            // refill pending: only the new level is taken
            if (!refill_on) begin
               rise_last = (key_level > stop_level) ? key_level - stop_level : 8'd0;
               refill_last = refill_on;
               refill_on = (rise_last >= cfg_threshold);
            end
         end
         OP_TICK: begin
            t32 = {16'd0, r.injection_time};
            k32 = {16'd0, r.injector_flow};
            dens = 32'd1792 + {24'd0, cfg_density};
            if (r.injection_time < SHORT_TIME_LIMIT) begin
               quot = (t32 << SHORT_SHIFT) / ((k32 + 32'd1) * dens);
            end else begin
               quot = (t32 << LONG_SHIFT) / dens;
               quot = (quot << POST_SHIFT) / (k32 + 32'd1);
            end
            fuel_tdc = (quot > 32'd65535) ? SAT16 : quot[15:0];
            if (refill_on) begin
               sum = {16'd0, fuel_used} + {16'd0, fuel_tdc};
               fuel_used = (sum > 32'd65535) ? SAT16 : sum[15:0];
               adapt_req = ({16'd0, fuel_used} >= CONSUME_MULT * {16'd0, cfg_volume});
            end
            // rising edge of reset done clears flag and request
            if (r.reset_done && !done_last) begin
               refill_on = 1'b0;
               adapt_req = 1'b0;
            end
            refill_last = refill_on;
            done_last = r.reset_done;
         end
         OP_EDGE: begin
            if (refill_on && !refill_last) begin
               mix = int'(stop_level) * (int'(r.previous_factor) - int'(cfg_fresh))
                   + int'(key_level) * int'(cfg_fresh);
               if (mix < 0) begin
                  quality_rst = 8'd0;
               end else if (key_level != 8'd0) begin
                  q_int = mix / int'(key_level);
                  quality_rst = (q_int > int'(FACTOR_MAX)) ? FACTOR_MAX : 8'(q_int);
               end else begin
                  quality_rst = FACTOR_MAX;
               end
               fuel_used = '0;
            end
         end
         default: begin
         end
      endcase
      s.refill_detected = refill_on;
      s.reset_factor = quality_rst;
      s.reset_request = adapt_req;
      s.level_rise = rise_last;
      s.fuel_per_tdc = fuel_tdc;
      s.consumed_since_refill = fuel_used;
      return s;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at result %0d: %s", results_seen, what);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (state_due_q.size() == 0) begin
         note_mismatch("result with no request outstanding");
         return;
      end
      want = state_due_q.pop_front();
      if (got.refill_detected !== want.refill_detected)
         note_mismatch($sformatf("refill_detected %0d, want %0d",
                                 got.refill_detected, want.refill_detected));
      if (got.reset_factor !== want.reset_factor)
         note_mismatch($sformatf("reset_factor %0d, want %0d",
                                 got.reset_factor, want.reset_factor));
      if (got.reset_request !== want.reset_request)
         note_mismatch($sformatf("reset_request %0d, want %0d",
                                 got.reset_request, want.reset_request));
      if (got.level_rise !== want.level_rise)
         note_mismatch($sformatf("level_rise %0d, want %0d",
                                 got.level_rise, want.level_rise));
      if (got.fuel_per_tdc !== want.fuel_per_tdc)
         note_mismatch($sformatf("fuel_per_tdc %0d, want %0d",
                                 got.fuel_per_tdc, want.fuel_per_tdc));
      if (got.consumed_since_refill !== want.consumed_since_refill)
         note_mismatch($sformatf("consumed_since_refill %0d, want %0d",
                                 got.consumed_since_refill, want.consumed_since_refill));
   endtask

   // Driver: one request at a time from the queue, random gap after each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            state_due_q.push_back(refill_state_after(req_data));
         if (send_wait != 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (request_q.size() != 0) begin
            req_data <= request_q.pop_front();
            req_valid <= 1'b1;
            send_wait <= send_quiet ? 0 : $urandom_range(0, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result, then stall for a random count
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else if (rsp_valid && rsp_ready) begin
         check_result(rsp_data);
         recv_draw = recv_quiet ? 0 : $urandom_range(0, 15);
         if (recv_draw != 0) begin
            rsp_ready <= 1'b0;
            recv_wait <= recv_draw;
         end
      end else if (!rsp_ready) begin
         if (recv_wait > 1) begin
            recv_wait <= recv_wait - 1;
         end else begin
            rsp_ready <= 1'b1;
            recv_wait <= 0;
         end
      end
   end

   // Register write, model copy updated alongside
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_THRESHOLD: cfg_threshold = val[7:0];
         CSR_FRESH:     cfg_fresh = val[7:0];
         CSR_VOLUME:    cfg_volume = val[15:0];
         CSR_DENSITY:   cfg_density = val[7:0];
         default: begin
         end
      endcase
   endtask

   task automatic set_config(input int unsigned thr, input int unsigned fresh,
                             input int unsigned vol, input int unsigned dens);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_FRESH, fresh);
      write_reg(CSR_VOLUME, vol);
      write_reg(CSR_DENSITY, dens);
      @(negedge clock);
   endtask

   // Hold until nothing is queued, in flight or outstanding
   task automatic wait_idle();
      do
         @(negedge clock);
      while (request_q.size() != 0 || req_valid || state_due_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic push(input req_type r);
      request_q.push_back(r);
      if (r.opcode <= OP_EDGE)
         requests_queued++;
   endtask

   // Request with every field random apart from the opcode
   function automatic req_type any_item(input logic [2:0] op);
      req_type r;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      r.opcode = op;
      return r;
   endfunction

   function automatic req_type level_item(input logic [2:0] op, input int unsigned lvl);
      req_type r;
      r = any_item(op);
      r.fuel_level = lvl[7:0];
      return r;
   endfunction

   function automatic req_type edge_item(input int unsigned pf);
      req_type r;
      r = any_item(OP_EDGE);
      r.previous_factor = pf[7:0];
      return r;
   endfunction

   function automatic req_type restore_item(input int unsigned f, input logic q);
      req_type r;
      r = any_item(OP_RESTORE);
      r.stored_factor = f[7:0];
      r.stored_request = q;
      return r;
   endfunction

   function automatic req_type tick_fixed(input int unsigned t, input int unsigned k,
                                          input logic done);
      req_type r;
      r = any_item(OP_TICK);
      r.injection_time = t[15:0];
      r.injector_flow = k[15:0];
      r.reset_done = done;
      return r;
   endfunction

   // Tick biased towards the short/long boundary and small constants
   function automatic req_type tick_item(input logic done);
      req_type r;
      r = any_item(OP_TICK);
      case ($urandom_range(0, 3))
         1: r.injection_time = 16'($urandom_range(0, 8190));
         2: r.injection_time = 16'($urandom_range(8185, 8200));
         3: r.injection_time = 16'($urandom_range(0, 300));
         default: begin
         end
      endcase
      if ($urandom_range(0, 1) != 0)
         r.injector_flow = 16'($urandom_range(0, 63));
      r.reset_done = done;
      return r;
   endfunction

   // Random phase: mostly refill sequences, some restores and noise
   task automatic fill_random(input int unsigned count);
      int unsigned goal, a, b, n;
      goal = requests_queued + count;
      while (requests_queued < goal) begin
         case ($urandom_range(0, 9))
            0: push(any_item(3'($urandom_range(0, 7))));
            1: push(restore_item($urandom_range(0, 255), 1'($urandom_range(0, 1))));
            default: begin
               a = $urandom_range(0, 255);
               if ($urandom_range(0, 3) != 0)
                  b = a + cfg_threshold + $urandom_range(0, 20);
               else
                  b = $urandom_range(0, 255);
               if (b > 255)
                  b = 255;
               push(level_item(OP_STOP, a));
               push(level_item(OP_KEY_ON, b));
               if ($urandom_range(0, 7) == 0)
                  push(level_item(OP_KEY_ON, $urandom_range(0, 255)));
               if ($urandom_range(0, 7) != 0)
                  push(edge_item($urandom_range(0, 255)));
               n = $urandom_range(1, 8);
               repeat (n) push(tick_item(1'b0));
               if ($urandom_range(0, 3) == 0)
                  push(edge_item($urandom_range(0, 255)));
               if ($urandom_range(0, 5) != 0) begin
                  push(tick_item(1'b1));
                  push(tick_item(1'b0));
               end
            end
         endcase
      end
   endtask

   // Run sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, register defaults
      push(restore_item(255, 1'b1));   // factor capped
      push(restore_item(0, 1'b0));
      push(restore_item(128, 1'b1));
      push(any_item(3'd5));            // unused opcodes
      push(any_item(3'd7));
      push(level_item(OP_STOP, 0));
      push(level_item(OP_KEY_ON, 255));   // full rise
      push(level_item(OP_KEY_ON, 0));     // refill pending
      push(edge_item(255));               // blend with zero new level
      push(edge_item(0));                 // still a rising edge: no tick in between
      push(tick_fixed(0, 0, 1'b0));
      push(tick_fixed(8190, 0, 1'b0));
      push(tick_fixed(8191, 65535, 1'b0));
      push(tick_fixed(65535, 0, 1'b0));
      push(tick_fixed(65535, 65535, 1'b1));
      push(tick_fixed(100, 3, 1'b1));
      push(tick_fixed(0, 0, 1'b0));
      push(level_item(OP_STOP, 200));
      push(level_item(OP_KEY_ON, 100));   // level fall
      push(level_item(OP_STOP, 100));
      push(level_item(OP_KEY_ON, 109));   // one short of the threshold
      push(level_item(OP_KEY_ON, 110));   // exactly the threshold
      push(edge_item(255));               // blend above range
      push(tick_fixed(8000, 0, 1'b0));    // consumption past the limit
      push(tick_fixed(8000, 0, 1'b1));
      push(tick_fixed(8000, 0, 1'b0));
      wait_idle();

      // Directed, zero threshold and volume, heaviest density
      set_config(0, 128, 0, 255);
      push(level_item(OP_STOP, 255));
      push(level_item(OP_KEY_ON, 10));    // fall still counts at threshold zero
      push(edge_item(0));                 // blend below zero
      push(tick_fixed(0, 0, 1'b0));       // zero volume requests at once
      push(tick_fixed(5000, 65535, 1'b0));
      push(edge_item(100));
      push(tick_fixed(300, 1, 1'b1));
      push(tick_fixed(300, 1, 1'b0));
      wait_idle();

      // Random phases under varied settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_config(0, 0, 0, 0);
            1: set_config(255, 255, 65535, 255);
            default: set_config($urandom_range(0, 40), $urandom_range(0, 255),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 1500),
                                $urandom_range(0, 255));
         endcase
         send_quiet = (phase == 3) || (phase == 5);
         recv_quiet = (phase == 4) || (phase == 5);
         fill_random(PHASE_REQUESTS);
         wait_idle();
      end

      repeat (80) @(negedge clock);
      if (mismatch_count == 0 && state_due_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/fuel_rd_pkg.sv
rtl/fuel_rd_div.sv
rtl/fuel_rd_core.sv
rtl/fuel_refill_detector_top.sv
rtl/fuel_rd_chk.sv
tb/tb.sv
